>>> design/temu_pkg.sv
// ----------------------------------------------------------------------------
// temu_pkg: shared types and constants of the toroidal energy map update
// Map geometry, fixed point formats, item kinds, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package temu_pkg;

	localparam int LOG_SIDE     = 7;
	localparam int ENERGY_WIDTH = 24;
	localparam int KERNEL_FRAC  = 16;

	localparam int SIDE    = 1 << LOG_SIDE;
	localparam int HALF    = SIDE / 2;
	localparam int AREA    = SIDE * SIDE;
	localparam int KDEPTH  = HALF * HALF;
	localparam int CELL_W  = 2 * LOG_SIDE;
	localparam int KADDR_W = 2 * (LOG_SIDE - 1);

	localparam int KIND_W  = 3;
	localparam int INDEX_W = 14;
	localparam int KVAL_W  = 16;

	localparam logic [ENERGY_WIDTH-1:0] E_MAX = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD   = 3'd0,
		KIND_PLACE  = 3'd1,
		KIND_REMOVE = 3'd2,
		KIND_INVERT = 3'd3,
		KIND_READD  = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_WRITE,
		ST_SWEEP,
		ST_DRAIN,
		ST_CLEAR,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic capture;
		logic kernel_we;
		logic occ_we;
		logic occ_val;
		logic step;
		logic clear;
		logic clear_occ;
		logic toggle_pol;
		logic clr_best;
		logic add;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic busy;
	} status_t;

endpackage

>>> design/temu_ram.sv
// ----------------------------------------------------------------------------
// temu_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle at independent addresses.
// ----------------------------------------------------------------------------
module temu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/temu_dp.sv
// ----------------------------------------------------------------------------
// temu_dp: datapath of the toroidal energy map update
// Holds the occupancy, energy and kernel memories, the cell counter and a
// three stage sweep pipeline: address and fold, saturating update, search.
// ----------------------------------------------------------------------------
module temu_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  temu_pkg::cmd_t                   cmd,
	output temu_pkg::status_t                status,
	input  logic [temu_pkg::INDEX_W-1:0]     index,
	input  logic [temu_pkg::KVAL_W-1:0]      kernel_value,
	output logic [temu_pkg::INDEX_W-1:0]     min_index,
	output logic [temu_pkg::INDEX_W-1:0]     max_index
);
	import temu_pkg::*;

	logic [INDEX_W-1:0]      index_q;
	logic [KERNEL_FRAC-1:0]  kval_q;
	logic [CELL_W-1:0]       cnt_q;
	logic                    pol_q;
	logic [CELL_W-1:0]       centre;

	// Stage 0 signals.
	logic [LOG_SIDE-1:0]     dx, dy, ndx, ndy;
	logic [LOG_SIDE-2:0]     fx, fy;
	logic [KADDR_W-1:0]      kaddr_s0;
	logic                    zero_s0;

	// Stage 1.
	logic                    v_s1, zero_s1;
	logic [CELL_W-1:0]       i_s1;
	logic [KERNEL_FRAC-1:0]  k_rd;
	logic [ENERGY_WIDTH-1:0] e_rd;
	logic [0:0]              occ_rd;
	logic [ENERGY_WIDTH-1:0] w, e_new;
	logic [ENERGY_WIDTH:0]   sum;

	// Stage 2.
	logic                    v_s2, occ_s2;
	logic [ENERGY_WIDTH-1:0] e_s2;
	logic [CELL_W-1:0]       i_s2;

	logic                    have_min_q;
	logic [ENERGY_WIDTH-1:0] best_min_q, best_max_q;
	logic [CELL_W-1:0]       lowest_q, highest_q;

	// Memory ports.
	logic                    e_we, o_we;
	logic [CELL_W-1:0]       e_waddr, o_waddr;
	logic [ENERGY_WIDTH-1:0] e_wdata;
	logic [0:0]              o_wdata;

	assign centre = CELL_W'(index_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			index_q <= index;
			kval_q  <= kernel_value[KERNEL_FRAC-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pol_q <= 1'b0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (cmd.step || cmd.clear) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.toggle_pol) begin
				pol_q <= ~pol_q;
			end
			v_s1 <= cmd.step;
			v_s2 <= v_s1;
		end
	end

	assign status.last = &cnt_q;
	assign status.busy = v_s1 | v_s2;

	// Toroidal distance from the centre, folded onto the quarter kernel.
	always_comb begin
		dx  = cnt_q[LOG_SIDE-1:0] - centre[LOG_SIDE-1:0];
		dy  = cnt_q[CELL_W-1:LOG_SIDE] - centre[CELL_W-1:LOG_SIDE];
		ndx = -dx;
		ndy = -dy;
		fx  = dx[LOG_SIDE-1] ? ndx[LOG_SIDE-2:0] : dx[LOG_SIDE-2:0];
		fy  = dy[LOG_SIDE-1] ? ndy[LOG_SIDE-2:0] : dy[LOG_SIDE-2:0];
		kaddr_s0 = {fy, fx};
		zero_s0  = (dx == LOG_SIDE'(HALF)) || (dy == LOG_SIDE'(HALF));
	end

	always_ff @(posedge clk) begin
		zero_s1 <= zero_s0;
		i_s1    <= cnt_q;
	end

	always_comb begin
		w     = zero_s1 ? '0 : ENERGY_WIDTH'(k_rd);
		sum   = {1'b0, e_rd} + {1'b0, w};
		if (cmd.add) begin
			e_new = sum[ENERGY_WIDTH] ? E_MAX : sum[ENERGY_WIDTH-1:0];
		end else begin
			e_new = (e_rd >= w) ? e_rd - w : '0;
		end
	end

	always_ff @(posedge clk) begin
		e_s2   <= e_new;
		occ_s2 <= occ_rd[0] ^ pol_q;
		i_s2   <= i_s1;
	end

	// Strict compares keep the first cell on ties.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_min_q <= 1'b0;
			best_max_q <= '0;
			lowest_q   <= '0;
			highest_q  <= '0;
		end else if (cmd.clr_best) begin
			have_min_q <= 1'b0;
			best_max_q <= '0;
		end else if (v_s2) begin
			if (occ_s2) begin
				if (e_s2 > best_max_q) begin
					best_max_q <= e_s2;
					highest_q  <= i_s2;
				end
			end else if (!have_min_q || e_s2 < best_min_q) begin
				have_min_q <= 1'b1;
				lowest_q   <= i_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && !occ_s2 && (!have_min_q || e_s2 < best_min_q)) begin
			best_min_q <= e_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			min_index <= INDEX_W'(lowest_q);
			max_index <= INDEX_W'(highest_q);
		end
	end

	always_comb begin
		e_we    = cmd.clear | v_s1;
		e_waddr = cmd.clear ? cnt_q : i_s1;
		e_wdata = cmd.clear ? '0 : e_new;
		o_we    = cmd.clear_occ | cmd.occ_we;
		o_waddr = cmd.clear_occ ? cnt_q : centre;
		o_wdata = cmd.clear_occ ? 1'b0 : (cmd.occ_val ^ pol_q);
	end

	temu_ram #(.WIDTH(ENERGY_WIDTH), .DEPTH(AREA)) u_energy (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (cnt_q),
		.rdata (e_rd)
	);

	temu_ram #(.WIDTH(1), .DEPTH(AREA)) u_occ (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (o_wdata),
		.raddr (cnt_q),
		.rdata (occ_rd)
	);

	temu_ram #(.WIDTH(KERNEL_FRAC), .DEPTH(KDEPTH)) u_kernel (
		.clk   (clk),
		.we    (cmd.kernel_we),
		.waddr (KADDR_W'(index_q)),
		.wdata (kval_q),
		.raddr (kaddr_s0),
		.rdata (k_rd)
	);

`ifndef ASSERT_OFF
	// A clearing pass must never share the energy write port with a sweep.
	a_clear_vs_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !(v_s1 || v_s2))
		else $error("energy clear overlaps sweep pipeline");

	// The centre cell must not change while the sweep is in flight.
	a_capture_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> !cmd.capture)
		else $error("new word captured during sweep");
`endif

endmodule

>>> design/temu_ctrl.sv
// ----------------------------------------------------------------------------
// temu_ctrl: controller of the toroidal energy map update
// Sequences the reset clearing pass, kernel and occupancy writes, sweeps,
// energy clears and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module temu_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [temu_pkg::KIND_W-1:0]   kind,
	output logic                          out_valid,
	input  logic                          out_stall,
	output temu_pkg::cmd_t                cmd,
	input  temu_pkg::status_t             status
);
	import temu_pkg::*;

	state_t state_q, state_d;
	kind_t  kind_q;
	kind_t  in_kind;
	logic   out_valid_q;

	assign in_kind   = kind_t'(kind);
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			kind_q      <= KIND_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				kind_q <= in_kind;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.add     = (kind_q != KIND_REMOVE);
		cmd.occ_val = (kind_q == KIND_PLACE);
		unique case (state_q)
			ST_INIT: begin
				cmd.clear     = 1'b1;
				cmd.clear_occ = 1'b1;
				if (status.last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					unique case (in_kind) inside
						KIND_LOAD, KIND_PLACE, KIND_REMOVE: begin
							state_d = ST_WRITE;
						end
						KIND_INVERT: begin
							cmd.toggle_pol = 1'b1;
							state_d        = ST_CLEAR;
						end
						KIND_READD: begin
							cmd.clr_best = 1'b1;
							state_d      = ST_SWEEP;
						end
						default: begin
							state_d = ST_RESULT;
						end
					endcase
				end
			end
			ST_WRITE: begin
				if (kind_q == KIND_LOAD) begin
					cmd.kernel_we = 1'b1;
					state_d       = ST_RESULT;
				end else begin
					cmd.occ_we   = 1'b1;
					cmd.clr_best = 1'b1;
					state_d      = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				cmd.step = 1'b1;
				if (status.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.busy) begin
					state_d = ST_RESULT;
				end
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.last) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	// A pending result word must never be overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("output register overwritten while stalled");

	// A new word is taken only once the sweep pipeline has drained.
	a_accept_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !status.busy)
		else $error("word accepted with sweep in flight");
`endif

endmodule

>>> design/toroidal_energy_map_update_unit.sv
// ----------------------------------------------------------------------------
// toroidal_energy_map_update_unit: void-and-cluster energy map update
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------
//   in      | in_valid / in_stall | kind, index, kernel_value
//   out     | out_valid/out_stall | min_index, max_index
//
// Place, remove and re-add sweep all 16384 cells at one cell per cycle
// through the energy memory port and then drain the sweep pipeline.
// Invert clears the energy memory. One word is worked on at a time.
// After reset a clearing pass zeroes occupancy and energy; in_stall stays
// high until it is done.
// A finished result waits in the output register while the next word is
// accepted; out_stall only holds back the hand-off of the following result.
// ----------------------------------------------------------------------------
module toroidal_energy_map_update_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [temu_pkg::KIND_W-1:0]   kind,
	input  logic [temu_pkg::INDEX_W-1:0]  index,
	input  logic [temu_pkg::KVAL_W-1:0]   kernel_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [temu_pkg::INDEX_W-1:0]  min_index,
	output logic [temu_pkg::INDEX_W-1:0]  max_index
);
	import temu_pkg::*;

	cmd_t    cmd;
	status_t status;

	temu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	temu_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.index        (index),
		.kernel_value (kernel_value),
		.min_index    (min_index),
		.max_index    (max_index)
	);

endmodule
